### design/rld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_pkg
// Types and constants that the reply deframer modules share: the input and
// result beat layouts, the framing characters and the status codes.
// ----------------------------------------------------------------------------
package rld_pkg;

  // Framing characters.
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Status codes reported with each result beat.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SKIPPED   = 3'd1;
  localparam logic [2:0] ST_MISSING_CR = 3'd2;
  localparam logic [2:0] ST_BROKEN    = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  // Register reset value, minimum length and default ring size.
  localparam logic [7:0] MAX_LEN_RESET  = 8'd80;
  localparam logic [7:0] MIN_LEN        = 8'd2;
  localparam int         RING_SIZE_DEF  = 256;

  // One input beat.
  typedef struct packed {
    logic [7:0] char_in;
    logic       new_response;
    logic [7:0] start_index;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] char_out;
    logic       stored;
    logic [7:0] position;
    logic [2:0] status;
    logic [7:0] next_index;
    logic       last;
  } out_item_t;

endpackage

### design/response_line_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// response_line_deframer_top
// Recognises controller replies framed as LF CR [CR] body LF CR [CR], one
// character per beat, and reports for each character its place, value,
// status, the next ring read index and the end of the reply.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------
//   input    | in_valid / in_stall  | in_item  (in_item_t)
//   result   | out_valid / out_stall| out_item (out_item_t)
//   config   | cfg_write            | cfg_data (max_response_length)
//
// One beat is taken every cycle unless in_stall holds the input; each result is
// offered once its beat has passed the input register and the framing
// update has loaded the result register.
// Reset clears the framing state, the read index and both stage valids and
// loads max_response_length with 80. A stall on the result side holds the
// result register and, when the input register is also full, stalls input.
// ----------------------------------------------------------------------------
module response_line_deframer_top import rld_pkg::*; #(
  parameter int RING_SIZE = RING_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data
);

  logic [7:0] max_response_length;
  logic       hold_valid;
  in_item_t   hold_item;
  logic       out_free;
  logic       step;
  out_item_t  result;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_response_length <= MAX_LEN_RESET;
    end else if (cfg_write) begin
      max_response_length <= cfg_data;
    end
  end

  // Pipeline flow: the result register takes a new beat when empty or drained.
  assign out_free = !out_valid || !out_stall;
  assign step     = hold_valid && out_free;
  assign in_stall = hold_valid && !out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_item <= in_item;
    end
  end

  // Framing update.
  rld_frame #(
    .RING_SIZE (RING_SIZE)
  ) u_frame (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (hold_item),
    .max_len (max_response_length),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= result;
    end
  end

endmodule

### design/rld_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_frame
// Framing state of the deframer and the single-pass update for one
// character: classifies the character, builds its result beat and advances
// the position, the framing flags and the wrapping ring read index.
// ----------------------------------------------------------------------------
module rld_frame import rld_pkg::*; #(
  parameter int RING_SIZE = RING_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  in_item_t   item,
  input  logic [7:0] max_len,
  output out_item_t  result
);

  // Framing state.
  logic [7:0] reply_position, reply_position_next;
  logic       double_cr_prefix, double_cr_prefix_next;
  logic       closing_lf_seen, closing_lf_seen_next;
  logic       first_closing_cr_seen, first_closing_cr_seen_next;
  logic [7:0] read_index, read_index_next;

  // Working values for the current character.
  logic [7:0] c;
  logic [7:0] n;
  logic       dbl, lf, fcr;
  logic [7:0] ridx;
  logic [8:0] ridx_inc;
  logic [7:0] ridx_adv;
  logic [7:0] limit;
  logic       ends;
  logic       dbl_n, lf_n, fcr_n;
  logic [7:0] c_o;
  logic [2:0] status;

  // A new reply clears the framing and reloads the read index first.
  always_comb begin
    c    = item.char_in;
    n    = item.new_response ? 8'd0 : reply_position;
    dbl  = item.new_response ? 1'b0 : double_cr_prefix;
    lf   = item.new_response ? 1'b0 : closing_lf_seen;
    fcr  = item.new_response ? 1'b0 : first_closing_cr_seen;
    ridx = item.new_response ? item.start_index : read_index;
    ridx_inc = {1'b0, ridx} + 9'd1;
    ridx_adv = (ridx_inc >= 9'(RING_SIZE)) ? 8'd0 : ridx_inc[7:0];
    limit    = (max_len < MIN_LEN) ? MIN_LEN : max_len;
  end

  // Character classification, result beat and next state.
  always_comb begin
    dbl_n  = dbl;
    lf_n   = lf;
    fcr_n  = fcr;
    c_o    = c;
    status = ST_OK;
    ends   = 1'b0;

    result = '0;
    reply_position_next        = reply_position;
    double_cr_prefix_next      = double_cr_prefix;
    closing_lf_seen_next       = closing_lf_seen;
    first_closing_cr_seen_next = first_closing_cr_seen;
    read_index_next            = read_index;

    if (n == 8'd0 && c != CH_LF) begin
      // Leading junk is consumed but not kept.
      result.char_out   = c;
      result.stored     = 1'b0;
      result.position   = 8'd0;
      result.status     = ST_SKIPPED;
      result.next_index = ridx_adv;
      result.last       = 1'b0;
      reply_position_next        = 8'd0;
      double_cr_prefix_next      = 1'b0;
      closing_lf_seen_next       = 1'b0;
      first_closing_cr_seen_next = 1'b0;
      read_index_next            = ridx_adv;
    end else if (n == 8'd1 && c != CH_CR) begin
      // The leading LF must be followed by CR; the character is not consumed.
      result.char_out   = c;
      result.stored     = 1'b0;
      result.position   = 8'd1;
      result.status     = ST_MISSING_CR;
      result.next_index = ridx;
      result.last       = 1'b1;
      reply_position_next        = 8'd0;
      double_cr_prefix_next      = 1'b0;
      closing_lf_seen_next       = 1'b0;
      first_closing_cr_seen_next = 1'b0;
      read_index_next            = ridx;
    end else begin
      // Prefix and terminator tracking.
      if (n == 8'd2) begin
        if (c == CH_CR) begin
          dbl_n = 1'b1;
        end
      end else if (n >= 8'd3) begin
        if (c == CH_LF) begin
          lf_n = 1'b1;
        end else if (lf) begin
          if (c != CH_CR) begin
            c_o    = 8'd0;
            status = ST_BROKEN;
            ends   = 1'b1;
          end else if (dbl && !fcr) begin
            fcr_n = 1'b1;
          end else begin
            ends = 1'b1;
          end
        end
      end

      // Truncation when the last usable place is filled.
      if (!ends && ({1'b0, n} + 9'd1 >= {1'b0, limit} - 9'd1)) begin
        status = ST_TRUNCATED;
        ends   = 1'b1;
      end

      result.char_out   = c_o;
      result.stored     = 1'b1;
      result.position   = n;
      result.status     = status;
      result.next_index = ridx_adv;
      result.last       = ends;
      read_index_next   = ridx_adv;
      if (ends) begin
        reply_position_next        = 8'd0;
        double_cr_prefix_next      = 1'b0;
        closing_lf_seen_next       = 1'b0;
        first_closing_cr_seen_next = 1'b0;
      end else begin
        reply_position_next        = n + 8'd1;
        double_cr_prefix_next      = dbl_n;
        closing_lf_seen_next       = lf_n;
        first_closing_cr_seen_next = fcr_n;
      end
    end
  end

  // State registers, updated once per character handled.
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_position        <= 8'd0;
      double_cr_prefix      <= 1'b0;
      closing_lf_seen       <= 1'b0;
      first_closing_cr_seen <= 1'b0;
      read_index            <= 8'd0;
    end else if (step) begin
      reply_position        <= reply_position_next;
      double_cr_prefix      <= double_cr_prefix_next;
      closing_lf_seen       <= closing_lf_seen_next;
      first_closing_cr_seen <= first_closing_cr_seen_next;
      read_index            <= read_index_next;
    end
  end

endmodule
